// File: design/crc16f_pkg.sv
package crc16f_pkg;

    // CRC-16/CCITT-FALSE parameters.
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_TOPBIT = 16'h8000;

    // Fill levels of the two-byte delay line.
    localparam logic [1:0] HELD_EMPTY = 2'd0;
    localparam logic [1:0] HELD_ONE   = 2'd1;
    localparam logic [1:0] HELD_FULL  = 2'd2;

    typedef logic [7:0]  data_t;
    typedef logic [15:0] crc_t;
    typedef logic [1:0]  held_cnt_t;

    // One byte through the CRC, MSB first, eight shift steps.
    function automatic crc_t crc_update(input crc_t crc, input data_t b);
        crc_t c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOPBIT) != '0)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: design/crc16f_if.sv
// Byte stream channel: one frame byte per transaction.
interface crc16f_byte_if;
    import crc16f_pkg::*;

    logic  valid;
    logic  ready;
    data_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Check result channel: one transaction per frame.
interface crc16f_result_if;
    import crc16f_pkg::*;

    logic valid;
    logic ready;
    logic frame_ok;
    crc_t computed_crc;
    crc_t received_crc;
    logic too_short;

    modport source (output valid, output frame_ok, output computed_crc,
                    output received_crc, output too_short, input ready);
    modport sink   (input valid, input frame_ok, input computed_crc,
                    input received_crc, input too_short, output ready);
endinterface

// File: design/crc16_ccitt_frame_checker.sv
// Channel | Dir | Payload                                          | Transaction
// frame   | in  | data_byte[7:0], last_byte                        | one frame byte
// check   | out | frame_ok, computed_crc, received_crc, too_short  | one per frame
//
// Bytes are taken every cycle unless a stalled result holds back a last byte;
// a byte goes through an input register, then the CRC update and compare
// logic, and the result of a last byte is then written to the output register.
// Reset (rst_n low) empties both registers and starts a new frame.
// A stalled result only holds back a last byte waiting behind it; other bytes
// keep flowing, so a new frame is accepted while the old result still waits.
module crc16_ccitt_frame_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    crc16f_byte_if.sink               frame,
    crc16f_result_if.source           check
);
    import crc16f_pkg::*;

    // Input register stage.
    logic       in_valid_reg;
    data_t      in_data_reg;
    logic       in_last_reg;

    // Frame state.
    crc_t       crc_reg, crc_next;
    data_t      held0_reg, held0_next;
    data_t      held1_reg, held1_next;
    held_cnt_t  count_reg, count_next;

    // Result register.
    logic       out_valid_reg;
    logic       ok_reg, ok_next;
    crc_t       comp_reg, comp_next;
    crc_t       rx_reg, rx_next;
    logic       short_reg, short_next;

    // Step values after pushing the byte in the input register.
    crc_t       crc_step;
    data_t      held0_step;
    data_t      held1_step;
    held_cnt_t  count_step;
    crc_t       rx_word;

    logic       out_free;
    logic       advance;

    // Handshake: the input stage moves on unless a last byte waits behind a blocked result.
    assign out_free    = !out_valid_reg || check.ready;
    assign advance     = in_valid_reg && (!in_last_reg || out_free);
    assign frame.ready = !in_valid_reg || advance;

    // Capture accepted bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            in_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_data_reg <= frame.data_byte;
            in_last_reg <= frame.last_byte;
        end
    end

    // Delay line push and CRC update for the registered byte.
    always_comb
    begin
        crc_step   = crc_reg;
        held0_step = held0_reg;
        held1_step = held1_reg;
        count_step = count_reg;
        case (count_reg)
            HELD_EMPTY:
            begin
                held0_step = in_data_reg;
                count_step = HELD_ONE;
            end
            HELD_ONE:
            begin
                held1_step = in_data_reg;
                count_step = HELD_FULL;
            end
            default:
            begin
                crc_step   = crc_update(crc_reg, held0_reg);
                held0_step = held1_reg;
                held1_step = in_data_reg;
                count_step = HELD_FULL;
            end
        endcase
        rx_word = {held0_step, held1_step};
    end

    // Next frame state and result fields.
    always_comb
    begin
        crc_next   = crc_step;
        held0_next = held0_step;
        held1_next = held1_step;
        count_next = count_step;
        comp_next  = crc_step;
        if (count_step == HELD_FULL)
        begin
            ok_next    = (crc_step == rx_word);
            rx_next    = rx_word;
            short_next = 1'b0;
        end
        else
        begin
            ok_next    = 1'b0;
            rx_next    = '0;
            short_next = 1'b1;
        end
        // The last byte closes the frame and restarts the checker.
        if (in_last_reg)
        begin
            crc_next   = CRC_INIT;
            held0_next = '0;
            held1_next = '0;
            count_next = HELD_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            held0_reg <= '0;
            held1_reg <= '0;
            count_reg <= HELD_EMPTY;
        end
        else if (advance)
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            count_reg <= count_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (check.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            ok_reg    <= ok_next;
            comp_reg  <= comp_next;
            rx_reg    <= rx_next;
            short_reg <= short_next;
        end
    end

    assign check.valid        = out_valid_reg;
    assign check.frame_ok     = ok_reg;
    assign check.computed_crc = comp_reg;
    assign check.received_crc = rx_reg;
    assign check.too_short    = short_reg;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import crc16f_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_TICKS = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    // Kinds of frames the random stimulus produces.
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_BIT,
        FRAME_RANDOM_TAIL,
        FRAME_SINGLE,
        FRAME_NOISE
    } frame_kind_t;

    typedef struct packed {
        data_t value;
        logic  last;
    } frame_byte_t;

    typedef struct packed {
        logic ok;
        crc_t computed;
        crc_t received;
        logic short_frame;
    } check_result_t;

    logic clk;
    logic rst_n;

    crc16f_byte_if   frame_bus ();
    crc16f_result_if check_bus ();

    crc16_ccitt_frame_checker dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame_bus),
        .check (check_bus)
    );

    // Bytes waiting to be offered, and frame checks waiting to come out.
    frame_byte_t   byte_queue[$];
    check_result_t expected_checks[$];

    // Mirror of the checker state.
    crc_t      crc_acc;
    data_t     delay_line[2];
    held_cnt_t delay_fill;

    int          sender_idle_pct;
    int          sink_stall_pct;
    int          offered_bytes;
    int          accepted_bytes;
    int          queued_items;
    int          error_count;
    int          cycle_count;
    int          hold_left;
    logic        pressure_req;
    logic        pressure_done;
    frame_byte_t next_byte;

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Bitwise CRC-16/CCITT-FALSE step over one byte, MSB first.
    function automatic crc_t crc_shift_byte(input crc_t seed, input data_t b);
        crc_t r;
        logic fb;
        r = seed;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Clear the mirrored frame state.
    task automatic clear_frame_state();
        crc_acc       = CRC_INIT;
        delay_line[0] = '0;
        delay_line[1] = '0;
        delay_fill    = HELD_EMPTY;
    endtask

    // Feed one accepted byte through the delay line and the CRC; on the last
    // byte of a frame, queue the check that the block should report.
    task automatic absorb_byte(input data_t b, input logic last);
        check_result_t res;
        crc_t          rx;
        if (delay_fill == HELD_FULL)
        begin
            crc_acc       = crc_shift_byte(crc_acc, delay_line[0]);
            delay_line[0] = delay_line[1];
            delay_line[1] = b;
        end
        else
        begin
            delay_line[delay_fill[0]] = b;
            delay_fill                = delay_fill + 1'b1;
        end
        if (last)
        begin
            if (delay_fill == HELD_FULL)
            begin
                rx               = {delay_line[0], delay_line[1]};
                res.ok           = (crc_acc == rx);
                res.computed     = crc_acc;
                res.received     = rx;
                res.short_frame  = 1'b0;
            end
            else
            begin
                res.ok           = 1'b0;
                res.computed     = crc_acc;
                res.received     = '0;
                res.short_frame  = 1'b1;
            end
            expected_checks.push_back(res);
            clear_frame_state();
        end
    endtask

    task automatic push_byte(input data_t v, input logic last);
        frame_byte_t fb;
        fb.value = v;
        fb.last  = last;
        byte_queue.push_back(fb);
        queued_items++;
    endtask

    // Queue one frame of the given kind; good, bad-bit and random-tail frames carry
    // a random payload of up to max_len bytes ahead of the two CRC bytes.
    task automatic queue_frame(input frame_kind_t kind, input int max_len);
        crc_t  c;
        data_t b;
        int    n;
        if (kind == FRAME_SINGLE)
        begin
            push_byte(data_t'($urandom), 1'b1);
        end
        else if (kind == FRAME_NOISE)
        begin
            // Unstructured bytes; a last flag may fall anywhere.
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                push_byte(data_t'($urandom), ($urandom_range(99) < 30) || (i == n - 1));
            end
        end
        else
        begin
            n = $urandom_range(0, max_len);
            c = CRC_INIT;
            for (int i = 0; i < n; i++)
            begin
                b = data_t'($urandom);
                c = crc_shift_byte(c, b);
                push_byte(b, 1'b0);
            end
            if (kind == FRAME_BAD_BIT)
            begin
                c = c ^ (crc_t'(1) << $urandom_range(15));
            end
            else if (kind == FRAME_RANDOM_TAIL)
            begin
                c = crc_t'($urandom);
            end
            push_byte(c[15:8], 1'b0);
            push_byte(c[7:0], 1'b1);
        end
    endtask

    // Random frames until the phase has queued about item_goal bytes.
    task automatic queue_random_phase(input int item_goal, input int max_len);
        int          start;
        int          roll;
        frame_kind_t kind;
        start = queued_items;
        while (queued_items - start < item_goal)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
                kind = FRAME_SINGLE;
            else if (roll < 66)
                kind = FRAME_GOOD;
            else if (roll < 80)
                kind = FRAME_BAD_BIT;
            else if (roll < 92)
                kind = FRAME_RANDOM_TAIL;
            else
                kind = FRAME_NOISE;
            // Most frames are short; a few are long.
            queue_frame(kind, ($urandom_range(99) < 10) ? 4 * max_len : max_len);
        end
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || frame_bus.valid)
        begin
            @(posedge clk);
        end
    endtask

    task automatic compare_check(input check_result_t want);
        if (check_bus.frame_ok !== want.ok)
        begin
            $error("frame_ok: expected %0d, got %0d", want.ok, check_bus.frame_ok);
            error_count++;
        end
        if (check_bus.computed_crc !== want.computed)
        begin
            $error("computed_crc: expected %h, got %h", want.computed, check_bus.computed_crc);
            error_count++;
        end
        if (check_bus.received_crc !== want.received)
        begin
            $error("received_crc: expected %h, got %h", want.received, check_bus.received_crc);
            error_count++;
        end
        if (check_bus.too_short !== want.short_frame)
        begin
            $error("too_short: expected %0d, got %0d", want.short_frame, check_bus.too_short);
            error_count++;
        end
    endtask

    // Byte driver: holds a transaction until it is taken, then offers the next.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            frame_bus.valid <= 1'b0;
        end
        else if (!(frame_bus.valid && accepted_bytes != offered_bytes))
        begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_byte           = byte_queue.pop_front();
                frame_bus.valid     <= 1'b1;
                frame_bus.data_byte <= next_byte.value;
                frame_bus.last_byte <= next_byte.last;
                offered_bytes++;
            end
            else
            begin
                frame_bus.valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            check_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            check_bus.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (pressure_req && !pressure_done)
        begin
            check_bus.ready <= 1'b0;
            hold_left       <= HOLD_CYCLES - 1;
            pressure_done   <= 1'b1;
        end
        else
        begin
            check_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor: predict on each accepted byte, check each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_bus.valid && frame_bus.ready)
            begin
                accepted_bytes++;
                absorb_byte(frame_bus.data_byte, frame_bus.last_byte);
            end
            if (check_bus.valid && check_bus.ready)
            begin
                if (expected_checks.size() == 0)
                begin
                    $error("check result with none expected");
                    error_count++;
                end
                else
                begin
                    compare_check(expected_checks.pop_front());
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        rst_n               = 1'b0;
        frame_bus.valid     = 1'b0;
        frame_bus.data_byte = '0;
        frame_bus.last_byte = 1'b0;
        check_bus.ready     = 1'b0;
        sender_idle_pct     = 0;
        sink_stall_pct      = 0;
        offered_bytes       = 0;
        accepted_bytes      = 0;
        queued_items        = 0;
        error_count         = 0;
        cycle_count         = 0;
        hold_left           = 0;
        pressure_req        = 1'b0;
        pressure_done       = 1'b0;
        clear_frame_state();

        repeat (RESET_TICKS) @(negedge clk);
        rst_n = 1'b1;

        // Directed frames: one-byte frames at both byte extremes.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        // Two-byte frames: the CRC over no bytes is all ones.
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // The standard check string "123456789" with its known CRC.
        for (int i = 0; i < 9; i++)
        begin
            push_byte(8'h31 + data_t'(i), 1'b0);
        end
        push_byte(8'h29, 1'b0);
        push_byte(8'hB1, 1'b1);
        // Three-byte frame whose trailer does not match.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drained();

        // No idling on either side.
        queue_random_phase(300, 12);
        wait_drained();

        // Sender idles often.
        sender_idle_pct = 48;
        queue_random_phase(300, 12);
        wait_drained();

        // Receiver stalls often.
        sender_idle_pct = 0;
        sink_stall_pct  = 48;
        queue_random_phase(300, 12);
        wait_drained();

        // Both sides idle now and then.
        sender_idle_pct = 8;
        sink_stall_pct  = 8;
        queue_random_phase(300, 12);
        wait_drained();

        // Long receiver hold-off against a steady stream of short frames.
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        pressure_req    = 1'b1;
        queue_random_phase(100, 1);
        wait_drained();

        // Let every expected result arrive, then watch for stray ones.
        while (expected_checks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_checks.size() != 0)
        begin
            $error("%0d check results never arrived", expected_checks.size());
            error_count++;
        end

        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
